>>> rtl/i2c_master_bit_sequencer_macros.svh
// ----------------------------------------------------------------------------
// I2C master bit sequencer assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted
`define I2CM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("i2cm assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("i2cm assertion failed");

`else

`define I2CM_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master bit sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    // Defaults
    localparam int unsigned COUNTER_BITS_DEF = 16;
    localparam logic [15:0] BIT_DELAY_RESET  = 16'd50;
    localparam logic [3:0]  BITS_PER_BYTE    = 4'd8;
    localparam int unsigned QUEUE_DEPTH      = 2;

    // Action codes on the input
    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_START  = 3'd1;
    localparam logic [2:0] ACT_STOP   = 3'd2;
    localparam logic [2:0] ACT_RSTART = 3'd3;
    localparam logic [2:0] ACT_WRITE  = 3'd4;
    localparam logic [2:0] ACT_READ   = 3'd5;
    localparam logic [2:0] ACT_ACK    = 3'd6;
    localparam logic [2:0] ACT_NACK   = 3'd7;

    // Classified command kind
    typedef enum logic [2:0] {
        K_TICK,
        K_START,
        K_STOP,
        K_RSTART,
        K_WRITE,
        K_READ,
        K_ACK,
        K_NACK
    } t_kind;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_seen;
    } t_out_item;

    // Entry of the queue between front and back
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       sda;
    } t_cmd;

endpackage

`default_nettype wire

>>> rtl/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts input items, classifies the action and queues them for the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 push,
    output logic                full,
    input  i2cm_pkg::t_in_item  i_in,
    output i2cm_pkg::t_cmd      o_cmd,
    output logic                o_cmd_valid,
    input  wire                 i_cmd_pop
);

    localparam int unsigned DEPTH = i2cm_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    i2cm_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    i2cm_pkg::t_cmd   w_cmd;
    logic             w_push;
    logic             w_pop;

    // Classify the action code
    always_comb begin
        w_cmd.data = i_in.data_byte;
        w_cmd.sda  = i_in.sda_in;
        case (i_in.action)
            i2cm_pkg::ACT_TICK:   w_cmd.kind = i2cm_pkg::K_TICK;
            i2cm_pkg::ACT_START:  w_cmd.kind = i2cm_pkg::K_START;
            i2cm_pkg::ACT_STOP:   w_cmd.kind = i2cm_pkg::K_STOP;
            i2cm_pkg::ACT_RSTART: w_cmd.kind = i2cm_pkg::K_RSTART;
            i2cm_pkg::ACT_WRITE:  w_cmd.kind = i2cm_pkg::K_WRITE;
            i2cm_pkg::ACT_READ:   w_cmd.kind = i2cm_pkg::K_READ;
            i2cm_pkg::ACT_ACK:    w_cmd.kind = i2cm_pkg::K_ACK;
            i2cm_pkg::ACT_NACK:   w_cmd.kind = i2cm_pkg::K_NACK;
            default:              w_cmd.kind = i2cm_pkg::K_TICK;
        endcase
    end

    assign full        = (r_count == CNT_W'(DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign w_push      = push && !full;
    assign w_pop       = i_cmd_pop && o_cmd_valid;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the classified transfer
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/i2cm_resq.sv
// ----------------------------------------------------------------------------
// i2cm_resq
// Result queue between the sequencer and the result port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_resq (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  i2cm_pkg::t_out_item  i_res,
    output logic                 o_full,
    output logic                 empty,
    input  wire                  pop,
    output i2cm_pkg::t_out_item  o_out
);

    localparam int unsigned DEPTH = i2cm_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    i2cm_pkg::t_out_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_full = (r_count == CNT_W'(DEPTH));
    assign empty  = (r_count == '0);
    assign o_out  = r_mem[r_rd_ptr];
    assign w_push = i_push && !o_full;
    assign w_pop  = pop && !empty;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the result transfer
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

endmodule

`default_nettype wire

>>> rtl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// Phase sequencer: plays out SCL/SDA for one queued transfer per cycle while the result queue has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_bit_sequencer_macros.svh"

module i2cm_seq #(
    parameter int unsigned COUNTER_BITS = i2cm_pkg::COUNTER_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  i2cm_pkg::t_cmd       i_cmd,
    input  wire                  i_cmd_valid,
    output logic                 o_cmd_pop,
    input  wire                  i_res_full,
    output logic                 o_res_push,
    output i2cm_pkg::t_out_item  o_res,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [15:0]           i_cfg_data
);

    localparam int unsigned CNT_W = COUNTER_BITS;
    localparam logic [32:0] CAP   = (33'd1 << COUNTER_BITS) - 33'd1;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST_A, PH_ST_B,
        PH_SP_A, PH_SP_B, PH_SP_C, PH_SP_D,
        PH_RS_A, PH_RS_B, PH_RS_C, PH_RS_D,
        PH_WR_LOW, PH_WR_DATA, PH_WR_HIGH, PH_WR_ALOW, PH_WR_AHIGH,
        PH_RD_LOW, PH_RD_HIGH, PH_RD_HOLD,
        PH_AK_A, PH_AK_B, PH_AK_C,
        PH_NK_A, PH_NK_B, PH_NK_C
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [3:0]       r_bit_index, n_bit_index;
    logic [7:0]       r_shift, n_shift;
    logic [CNT_W-1:0] r_delay, n_delay;
    logic             r_scl, n_scl;
    logic             r_sda, n_sda;
    logic             r_ack, n_ack;
    logic [7:0]       r_rd_hold, n_rd_hold;
    logic [15:0]      r_bit_delay;
    logic             n_done;
    logic             w_fire;
    logic             w_enter;
    logic             w_full_delay;
    t_phase           w_target;
    logic [15:0]      w_span;
    logic [32:0]      w_span_ext;

    assign w_fire      = i_cmd_valid && !i_res_full;
    assign o_cmd_pop   = w_fire;
    assign o_res_push  = w_fire;
    assign o_cfg_ready = 1'b1;

    // Next phase, pins and counters for the transfer at the head of the queue
    always_comb begin
        n_phase      = r_phase;
        n_bit_index  = r_bit_index;
        n_shift      = r_shift;
        n_delay      = r_delay;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_ack        = r_ack;
        n_rd_hold    = r_rd_hold;
        n_done       = 1'b0;
        w_enter      = 1'b0;
        w_target     = PH_IDLE;
        w_full_delay = 1'b0;
        w_span       = '0;
        w_span_ext   = '0;

        if (r_phase == PH_IDLE) begin
            // Idle: start a command, ticks do nothing
            n_bit_index = '0;
            case (i_cmd.kind)
                i2cm_pkg::K_START: begin
                    w_enter = 1'b1; w_target = PH_ST_A;
                end
                i2cm_pkg::K_STOP: begin
                    w_enter = 1'b1; w_target = PH_SP_A;
                end
                i2cm_pkg::K_RSTART: begin
                    w_enter = 1'b1; w_target = PH_RS_A;
                end
                i2cm_pkg::K_WRITE: begin
                    n_shift = i_cmd.data;
                    w_enter = 1'b1; w_target = PH_WR_LOW;
                end
                i2cm_pkg::K_READ: begin
                    n_shift = '0;
                    w_enter = 1'b1; w_target = PH_RD_LOW;
                end
                i2cm_pkg::K_ACK: begin
                    w_enter = 1'b1; w_target = PH_AK_A;
                end
                i2cm_pkg::K_NACK: begin
                    w_enter = 1'b1; w_target = PH_NK_A;
                end
                default: ;
            endcase
        end else if (r_delay > CNT_W'(1)) begin
            // Hold the current phase
            n_delay = r_delay - CNT_W'(1);
        end else begin
            // Finish the phase and pick its successor
            w_enter = 1'b1;
            case (r_phase)
                PH_ST_A:    w_target = PH_ST_B;
                PH_SP_A:    w_target = PH_SP_B;
                PH_SP_B:    w_target = PH_SP_C;
                PH_SP_C:    w_target = PH_SP_D;
                PH_RS_A:    w_target = PH_RS_B;
                PH_RS_B:    w_target = PH_RS_C;
                PH_RS_C:    w_target = PH_RS_D;
                PH_WR_LOW:  w_target = PH_WR_DATA;
                PH_WR_DATA: w_target = PH_WR_HIGH;
                PH_WR_HIGH: begin
                    n_shift     = {r_shift[6:0], 1'b0};
                    n_bit_index = r_bit_index + 4'd1;
                    w_target    = (n_bit_index >= i2cm_pkg::BITS_PER_BYTE) ?
                                  PH_WR_ALOW : PH_WR_LOW;
                end
                PH_WR_ALOW: w_target = PH_WR_AHIGH;
                PH_WR_AHIGH: begin
                    n_ack   = ~i_cmd.sda;
                    w_enter = 1'b0;
                end
                PH_RD_LOW:  w_target = PH_RD_HIGH;
                PH_RD_HIGH: begin
                    n_shift  = {r_shift[6:0], i_cmd.sda};
                    w_target = PH_RD_HOLD;
                end
                PH_RD_HOLD: begin
                    n_bit_index = r_bit_index + 4'd1;
                    if (n_bit_index >= i2cm_pkg::BITS_PER_BYTE) begin
                        n_rd_hold = r_shift;
                        w_enter   = 1'b0;
                    end else begin
                        w_target = PH_RD_LOW;
                    end
                end
                PH_AK_A:    w_target = PH_AK_B;
                PH_AK_B:    w_target = PH_AK_C;
                PH_NK_A:    w_target = PH_NK_B;
                PH_NK_B:    w_target = PH_NK_C;
                default:    w_enter  = 1'b0;
            endcase
            if (!w_enter) begin
                n_phase = PH_IDLE;
                n_delay = '0;
                n_done  = 1'b1;
            end
        end

        // Enter the new phase: set pins and load its delay
        if (w_enter) begin
            n_phase = w_target;
            case (w_target)
                PH_ST_A:     begin n_scl = 1'b1; n_sda = 1'b1; w_full_delay = 1'b1; end
                PH_ST_B:     begin n_sda = 1'b0; w_full_delay = 1'b1; end
                PH_SP_A:     n_scl = 1'b0;
                PH_SP_B:     n_sda = 1'b0;
                PH_SP_C:     n_scl = 1'b1;
                PH_SP_D:     begin n_sda = 1'b1; w_full_delay = 1'b1; end
                PH_RS_A:     n_scl = 1'b0;
                PH_RS_B:     n_sda = 1'b1;
                PH_RS_C:     n_scl = 1'b1;
                PH_RS_D:     begin n_sda = 1'b0; w_full_delay = 1'b1; end
                PH_WR_LOW:   begin n_scl = 1'b0; w_full_delay = 1'b1; end
                PH_WR_DATA:  n_sda = n_shift[7];
                PH_WR_HIGH:  begin n_scl = 1'b1; w_full_delay = 1'b1; end
                PH_WR_ALOW:  begin n_scl = 1'b0; n_sda = 1'b1; end
                PH_WR_AHIGH: begin n_scl = 1'b1; n_sda = 1'b1; w_full_delay = 1'b1; end
                PH_RD_LOW:   begin n_scl = 1'b0; n_sda = 1'b1; w_full_delay = 1'b1; end
                PH_RD_HIGH:  n_scl = 1'b1;
                PH_RD_HOLD:  w_full_delay = 1'b1;
                PH_AK_A:     n_scl = 1'b0;
                PH_AK_B:     n_sda = 1'b0;
                PH_AK_C:     begin n_scl = 1'b1; w_full_delay = 1'b1; end
                PH_NK_A:     n_scl = 1'b0;
                PH_NK_B:     n_sda = 1'b1;
                PH_NK_C:     begin n_scl = 1'b1; w_full_delay = 1'b1; end
                default:     ;
            endcase
            // Full or half delay, at least one tick, saturated to the counter
            w_span = w_full_delay ? r_bit_delay : {1'b0, r_bit_delay[15:1]};
            if (w_span == '0) begin
                w_span = 16'd1;
            end
            w_span_ext = {17'd0, w_span};
            n_delay = (w_span_ext > CAP) ? CAP[CNT_W-1:0] : w_span_ext[CNT_W-1:0];
        end
    end

    // Result of this transfer
    always_comb begin
        o_res.scl_out   = n_scl;
        o_res.sda_out   = n_sda;
        o_res.busy_res  = (n_phase != PH_IDLE);
        o_res.done_res  = n_done;
        o_res.read_data = n_rd_hold;
        o_res.ack_seen  = n_ack;
    end

    // Hold state and advance on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_index <= '0;
            r_shift     <= '0;
            r_delay     <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_ack       <= 1'b0;
            r_rd_hold   <= '0;
        end else if (w_fire) begin
            r_phase     <= n_phase;
            r_bit_index <= n_bit_index;
            r_shift     <= n_shift;
            r_delay     <= n_delay;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_ack       <= n_ack;
            r_rd_hold   <= n_rd_hold;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_delay <= i2cm_pkg::BIT_DELAY_RESET;
        end else if (i_cfg_valid) begin
            r_bit_delay <= i_cfg_data;
        end
    end

    `I2CM_ASSERT_NOW(a_start_not_done, i_clk, i_rst_n, w_fire && (r_phase == PH_IDLE), !n_done)
    `I2CM_ASSERT_NOW(a_bit_index_range, i_clk, i_rst_n, 1'b1, r_bit_index <= i2cm_pkg::BITS_PER_BYTE)
    `I2CM_ASSERT_NOW(a_busy_has_delay, i_clk, i_rst_n, r_phase != PH_IDLE, r_delay != '0)
    `I2CM_ASSERT_NEXT(a_hold_phase, i_clk, i_rst_n, w_fire && (r_phase != PH_IDLE) && (r_delay > CNT_W'(1)), (r_phase == $past(r_phase)) && (r_delay == $past(r_delay) - CNT_W'(1)))

endmodule

`default_nettype wire

>>> rtl/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// I2C master that turns commands and ticks into SCL/SDA drive levels.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  input     push / full               i_in  (action, data_byte, sda_in)
//  result    empty / pop               o_out (scl, sda, busy, done, rdata, ack)
//  config    i_cfg_valid / o_cfg_ready i_cfg_data (bit_delay)
//
//  One item per clock while the queues have room; every item gives exactly one result.
//  A result is registered twice on its way to o_out: into the
//  command queue, then through the phase sequencer into the result queue.
//  The sequencer steps one queued item per cycle while the result queue has room.
//  Reset clears both queues, parks the bus released and sets bit_delay to 50.
//  A stalled result side fills the queues and then raises full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_sequencer #(
    parameter int unsigned COUNTER_BITS = i2cm_pkg::COUNTER_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  push,
    output logic                 full,
    input  i2cm_pkg::t_in_item   i_in,
    output logic                 empty,
    input  wire                  pop,
    output i2cm_pkg::t_out_item  o_out,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [15:0]           i_cfg_data
);

    i2cm_pkg::t_cmd      w_cmd;
    logic                w_cmd_valid;
    logic                w_cmd_pop;
    logic                w_res_full;
    logic                w_res_push;
    i2cm_pkg::t_out_item w_res;

    // Accept and classify
    i2cm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    // Play out the bus phases
    i2cm_seq #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Queue results for the consumer
    i2cm_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .o_full  (w_res_full),
        .empty   (empty),
        .pop     (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
